// ===== rtl/rfa_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the register file ALU.
package rfa_pkg;

    localparam int FUNC_W    = 3;
    localparam int INSTR_W   = 32;
    localparam int LOAD_W    = 32;
    localparam int RESULT_W  = 32;
    localparam int IDX_W     = 6;
    localparam int SRC_A_POS = 20;
    localparam int SRC_B_POS = 14;
    localparam int DEST_POS  = 8;

    typedef enum logic [FUNC_W-1:0] {
        FN_ADD  = 3'd0,
        FN_SUB  = 3'd1,
        FN_MUL  = 3'd2,
        FN_DIV  = 3'd3,
        FN_LOAD = 3'd4
    } t_func;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_A,
        S_RD_B,
        S_START,
        S_EXEC,
        S_DONE
    } t_seq_state;

    typedef enum logic [2:0] {
        A_IDLE,
        A_ARITH,
        A_MUL,
        A_ABS_A,
        A_ABS_B,
        A_DIV,
        A_FIX
    } t_alu_state;

endpackage

// ===== rtl/rfa_in_if.sv =====
`timescale 1ns / 1ps
// Input channel: operation selector, instruction word and load value.
interface rfa_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [rfa_pkg::FUNC_W-1:0]           func;
    logic [rfa_pkg::INSTR_W-1:0]          instruction;
    logic signed [rfa_pkg::LOAD_W-1:0]    load_value;

    modport source (output valid, output func, output instruction, output load_value,
                    input ready);
    modport sink (input valid, input func, input instruction, input load_value,
                  output ready);
endinterface

// ===== rtl/rfa_out_if.sv =====
`timescale 1ns / 1ps
// Output channel: written value, destination index and divide-by-zero flag.
interface rfa_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [rfa_pkg::RESULT_W-1:0]  result;
    logic [rfa_pkg::IDX_W-1:0]            dest_index;
    logic                                 divide_by_zero;

    modport source (output valid, output result, output dest_index, output divide_by_zero,
                    input ready);
    modport sink (input valid, input result, input dest_index, input divide_by_zero,
                  output ready);
endinterface

// ===== rtl/rfa_ram.sv =====
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
module rfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/rfa_alu.sv =====
`timescale 1ns / 1ps
// Iterative arithmetic unit: one shared adder does add, subtract, multiply and divide.
module rfa_alu #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rfa_pkg::t_alu_req     i_req,
    input  logic [DATA_WIDTH-1:0] i_a,
    input  logic [DATA_WIDTH-1:0] i_b,
    output logic                  o_done,
    output logic [DATA_WIDTH-1:0] o_result
);

    localparam int CW = $clog2(DATA_WIDTH + 1);
    localparam int SW = DATA_WIDTH + 1;

    rfa_pkg::t_alu_state r_state, n_state;
    logic [DATA_WIDTH-1:0] r_x, n_x;
    logic [DATA_WIDTH-1:0] r_y, n_y;
    logic [DATA_WIDTH-1:0] r_acc, n_acc;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic                  r_neg, n_neg;
    logic                  r_sub, n_sub;
    logic                  r_done, n_done;

    logic [SW-1:0] add_x;
    logic [SW-1:0] add_y;
    logic [SW-1:0] add_sum;
    logic          add_sub;

    // The one adder; subtraction inverts the second operand and carries in a one.
    assign add_sum = add_x + (add_y ^ {SW{add_sub}}) + SW'(add_sub);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rfa_pkg::A_IDLE: begin
                if (i_req.start) begin
                    unique case (i_req.op)
                        rfa_pkg::ALU_MUL: n_state = rfa_pkg::A_MUL;
                        rfa_pkg::ALU_DIV: n_state = rfa_pkg::A_ABS_A;
                        default:          n_state = rfa_pkg::A_ARITH;
                    endcase
                end
            end
            rfa_pkg::A_ARITH: n_state = rfa_pkg::A_IDLE;
            rfa_pkg::A_MUL: begin
                if (r_cnt == CW'(1)) begin
                    n_state = rfa_pkg::A_IDLE;
                end
            end
            rfa_pkg::A_ABS_A: n_state = rfa_pkg::A_ABS_B;
            rfa_pkg::A_ABS_B: n_state = rfa_pkg::A_DIV;
            rfa_pkg::A_DIV: begin
                if (r_cnt == CW'(1)) begin
                    n_state = rfa_pkg::A_FIX;
                end
            end
            rfa_pkg::A_FIX: n_state = rfa_pkg::A_IDLE;
            default:        n_state = rfa_pkg::A_IDLE;
        endcase
    end

    always_comb begin
        n_x     = r_x;
        n_y     = r_y;
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        n_neg   = r_neg;
        n_sub   = r_sub;
        n_done  = 1'b0;
        add_x   = '0;
        add_y   = '0;
        add_sub = 1'b0;
        unique case (r_state)
            rfa_pkg::A_IDLE: begin
                if (i_req.start) begin
                    n_x   = i_a;
                    n_y   = i_b;
                    n_acc = '0;
                    n_cnt = CW'(DATA_WIDTH);
                    n_sub = (i_req.op == rfa_pkg::ALU_SUB);
                    n_neg = i_a[DATA_WIDTH-1] ^ i_b[DATA_WIDTH-1];
                end
            end
            rfa_pkg::A_ARITH: begin
                add_x   = {1'b0, r_x};
                add_y   = {1'b0, r_y};
                add_sub = r_sub;
                n_acc   = add_sum[DATA_WIDTH-1:0];
                n_done  = 1'b1;
            end
            rfa_pkg::A_MUL: begin
                // Shift-and-add, one multiplier bit per cycle; only the low word is kept.
                add_x = {1'b0, r_acc};
                add_y = {1'b0, r_x};
                if (r_y[0]) begin
                    n_acc = add_sum[DATA_WIDTH-1:0];
                end
                n_x   = r_x << 1;
                n_y   = r_y >> 1;
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    n_done = 1'b1;
                end
            end
            rfa_pkg::A_ABS_A: begin
                add_y   = {1'b0, r_x};
                add_sub = 1'b1;
                if (r_x[DATA_WIDTH-1]) begin
                    n_x = add_sum[DATA_WIDTH-1:0];
                end
            end
            rfa_pkg::A_ABS_B: begin
                add_y   = {1'b0, r_y};
                add_sub = 1'b1;
                if (r_y[DATA_WIDTH-1]) begin
                    n_y = add_sum[DATA_WIDTH-1:0];
                end
            end
            rfa_pkg::A_DIV: begin
                // Restoring division: the dividend shifts out of r_x as quotient bits shift in.
                add_x   = {r_acc, r_x[DATA_WIDTH-1]};
                add_y   = {1'b0, r_y};
                add_sub = 1'b1;
                if (!add_sum[DATA_WIDTH]) begin
                    n_acc = add_sum[DATA_WIDTH-1:0];
                end else begin
                    n_acc = add_x[DATA_WIDTH-1:0];
                end
                n_x   = {r_x[DATA_WIDTH-2:0], !add_sum[DATA_WIDTH]};
                n_cnt = r_cnt - CW'(1);
            end
            rfa_pkg::A_FIX: begin
                add_y   = {1'b0, r_x};
                add_sub = 1'b1;
                n_acc   = r_neg ? add_sum[DATA_WIDTH-1:0] : r_x;
                n_done  = 1'b1;
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rfa_pkg::A_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x   <= n_x;
        r_y   <= n_y;
        r_acc <= n_acc;
        r_cnt <= n_cnt;
        r_neg <= n_neg;
        r_sub <= n_sub;
    end

    assign o_done   = r_done;
    assign o_result = r_acc;

    a_start_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> r_state == rfa_pkg::A_IDLE)
        else $error("ALU started while busy");

    a_done_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_state == rfa_pkg::A_IDLE)
        else $error("ALU reported done but is still running");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("ALU reported done for more than one cycle");

endmodule

// ===== rtl/register_file_alu_top.sv =====
`timescale 1ns / 1ps
// Top level of the register file ALU: sequencer, register file and output register.
//
// Usage: each input item carries an operation (add, subtract, multiply, signed
// divide, load), an instruction word whose bits 25..20 and 19..14 name the
// source registers and bits 13..8 the destination, and a load value. Each item
// yields exactly one output item with the written value, the destination index
// and a divide-by-zero flag; a divide by zero or an unused operation writes
// nothing and reports a zero value.
// Timing: the block takes one item at a time. The two source registers are read
// one after the other through the single RAM read port, then the shared adder
// iterates; load, no-op and a divide by zero skip the adder. The multiply and
// divide loops take one bit per cycle. The sequencer returns to idle when a
// result is registered and can then accept the next item.
// Reset clears all registers of the file to zero at once through per-entry
// valid bits; no clearing pass is needed. The input is not ready while reset is
// held. A stalled receiver holds the finished item in the output register; the
// block still accepts and computes the next item and waits only when that one is
// ready to leave.
module register_file_alu_top #(
    parameter int REG_COUNT  = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rfa_in_if.sink    i_in,
    rfa_out_if.source o_out
);

    localparam int AW   = $clog2(REG_COUNT);
    localparam int IW   = rfa_pkg::IDX_W;
    localparam int LW   = rfa_pkg::LOAD_W;
    localparam int RW   = rfa_pkg::RESULT_W;

    rfa_pkg::t_seq_state r_state, n_state;

    rfa_pkg::t_func        r_func;
    logic [IW-1:0]         r_ia;
    logic [IW-1:0]         r_ib;
    logic [IW-1:0]         r_id;
    logic [DATA_WIDTH-1:0] r_load;
    logic [DATA_WIDTH-1:0] r_a;
    logic                  r_rd_ok;
    logic                  r_dz;
    logic [REG_COUNT-1:0]  r_valid;

    logic                  r_out_valid;
    logic [RW-1:0]         r_out_result;
    logic [IW-1:0]         r_out_dest;
    logic                  r_out_dz;

    rfa_pkg::t_alu_req     alu_req;
    logic                  alu_done;
    logic [DATA_WIDTH-1:0] alu_result;

    logic                  accept;
    logic                  out_free;
    logic [IW-1:0]         rd_idx;
    logic                  rd_in_range;
    logic                  rd_ok;
    logic [AW-1:0]         rd_addr;
    logic [DATA_WIDTH-1:0] ram_rdata;
    logic [DATA_WIDTH-1:0] rd_value;
    logic                  b_zero;
    logic                  alu_go;
    logic                  dest_in_range;
    logic                  wr;
    logic [DATA_WIDTH-1:0] wr_value;
    logic                  rf_we;
    logic [DATA_WIDTH+LW-1:0] lv_ext;
    logic [DATA_WIDTH+RW-1:0] res_ext;

    assign accept   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;

    // Source reads: A is addressed in S_RD_A, B in S_RD_B.
    assign rd_idx      = (r_state == rfa_pkg::S_RD_A) ? r_ia : r_ib;
    assign rd_in_range = ({1'b0, rd_idx} < (IW + 1)'(REG_COUNT));
    assign rd_addr     = rd_idx[AW-1:0];
    assign rd_ok       = rd_in_range && r_valid[rd_addr];
    assign rd_value    = r_rd_ok ? ram_rdata : '0;

    assign b_zero        = (rd_value == '0);
    assign dest_in_range = ({1'b0, r_id} < (IW + 1)'(REG_COUNT));

    assign lv_ext  = {{DATA_WIDTH{i_in.load_value[LW-1]}}, i_in.load_value};
    assign res_ext = {{RW{1'b0}}, wr_value};

    always_comb begin
        unique case (r_func) inside
            rfa_pkg::FN_ADD, rfa_pkg::FN_SUB, rfa_pkg::FN_MUL: alu_go = 1'b1;
            rfa_pkg::FN_DIV: alu_go = !b_zero;
            default:         alu_go = 1'b0;
        endcase
    end

    always_comb begin
        unique case (r_func) inside
            rfa_pkg::FN_ADD, rfa_pkg::FN_SUB, rfa_pkg::FN_MUL: begin
                wr       = 1'b1;
                wr_value = alu_result;
            end
            rfa_pkg::FN_DIV: begin
                wr       = !r_dz;
                wr_value = r_dz ? '0 : alu_result;
            end
            rfa_pkg::FN_LOAD: begin
                wr       = 1'b1;
                wr_value = r_load;
            end
            default: begin
                wr       = 1'b0;
                wr_value = '0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rfa_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = rfa_pkg::S_RD_A;
                end
            end
            rfa_pkg::S_RD_A:  n_state = rfa_pkg::S_RD_B;
            rfa_pkg::S_RD_B:  n_state = rfa_pkg::S_START;
            rfa_pkg::S_START: n_state = alu_go ? rfa_pkg::S_EXEC : rfa_pkg::S_DONE;
            rfa_pkg::S_EXEC: begin
                if (alu_done) begin
                    n_state = rfa_pkg::S_DONE;
                end
            end
            rfa_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = rfa_pkg::S_IDLE;
                end
            end
            default: n_state = rfa_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready    = 1'b0;
        alu_req.start = 1'b0;
        alu_req.op    = rfa_pkg::ALU_ADD;
        rf_we         = 1'b0;
        unique case (r_state)
            rfa_pkg::S_IDLE: i_in.ready = i_rst_n;
            rfa_pkg::S_START: begin
                alu_req.start = alu_go;
                unique case (r_func)
                    rfa_pkg::FN_SUB: alu_req.op = rfa_pkg::ALU_SUB;
                    rfa_pkg::FN_MUL: alu_req.op = rfa_pkg::ALU_MUL;
                    rfa_pkg::FN_DIV: alu_req.op = rfa_pkg::ALU_DIV;
                    default:         alu_req.op = rfa_pkg::ALU_ADD;
                endcase
            end
            rfa_pkg::S_DONE: rf_we = out_free && wr && dest_in_range;
            default: begin
                rf_we = 1'b0;
            end
        endcase
    end

    rfa_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (REG_COUNT)
    ) u_rf (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (r_id[AW-1:0]),
        .i_wdata (wr_value),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    rfa_alu #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (alu_req),
        .i_a      (r_a),
        .i_b      (rd_value),
        .o_done   (alu_done),
        .o_result (alu_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rfa_pkg::S_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (rf_we) begin
                r_valid[r_id[AW-1:0]] <= 1'b1;
            end
            if (r_state == rfa_pkg::S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_ok <= rd_ok;
        if (accept) begin
            r_func <= rfa_pkg::t_func'(i_in.func);
            r_ia   <= i_in.instruction[rfa_pkg::SRC_A_POS +: IW];
            r_ib   <= i_in.instruction[rfa_pkg::SRC_B_POS +: IW];
            r_id   <= i_in.instruction[rfa_pkg::DEST_POS +: IW];
            r_load <= lv_ext[DATA_WIDTH-1:0];
        end
        if (r_state == rfa_pkg::S_RD_B) begin
            r_a <= rd_value;
        end
        if (r_state == rfa_pkg::S_START) begin
            r_dz <= (r_func == rfa_pkg::FN_DIV) && b_zero;
        end
        if (r_state == rfa_pkg::S_DONE && out_free) begin
            r_out_result <= res_ext[RW-1:0];
            r_out_dest   <= r_id;
            r_out_dz     <= r_dz;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.result         = r_out_result;
    assign o_out.dest_index     = r_out_dest;
    assign o_out.divide_by_zero = r_out_dz;

    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state == rfa_pkg::S_RD_A)
        else $error("Accepted item did not start its register reads");

    a_start_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_req.start |=> r_state == rfa_pkg::S_EXEC)
        else $error("ALU started without the sequencer waiting on it");

    a_dz_no_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_dz) |-> r_out_result == '0)
        else $error("Divide by zero reported with a nonzero value");

endmodule

// ===== tb/tb_register_file_alu_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the register file ALU: directed and random instructions.
module tb_register_file_alu_top;

    localparam int NUM_REGS      = 64;
    localparam int WORD_W        = 32;
    localparam int RANDOM_ITEMS  = 1380;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int DRAIN_CYCLES  = 60;
    localparam int QUIET_FIRST   = 700;
    localparam int QUIET_LAST    = 1000;
    localparam int IDLE_PERCENT  = 8;

    typedef logic [rfa_pkg::FUNC_W-1:0] t_func_code;
    typedef logic [rfa_pkg::IDX_W-1:0]  t_idx;

    // Selector codes that the block treats as no operation.
    localparam t_func_code FN_UNUSED_FIRST = 3'd5;
    localparam t_func_code FN_UNUSED_LAST  = 3'd7;

    typedef struct {
        t_func_code                   func;
        logic [rfa_pkg::INSTR_W-1:0]  instruction;
        logic [rfa_pkg::LOAD_W-1:0]   load_value;
    } t_alu_cmd;

    typedef struct packed {
        logic [rfa_pkg::RESULT_W-1:0] result;
        t_idx                         dest_index;
        logic                         divide_by_zero;
    } t_alu_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rfa_in_if  alu_in ();
    rfa_out_if alu_out ();

    register_file_alu_top #(
        .REG_COUNT (NUM_REGS),
        .DATA_WIDTH(WORD_W)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (alu_in),
        .o_out  (alu_out)
    );

    always #5 i_clk = ~i_clk;

    t_alu_cmd                     cmd_q[$];
    t_alu_result                  writeback_q[$];
    logic [rfa_pkg::RESULT_W-1:0] reg_model [NUM_REGS];
    logic                         in_fire = 1'b0;
    int                           accepted_count = 0;
    int                           mismatch_count = 0;
    int                           cycle_count = 0;
    int                           zero_div_count = 0;
    int                           op_seen [8];

    // Executes one instruction on the shadow register file and returns the
    // item the block should report for it.
    function automatic t_alu_result alu_execute(input t_func_code fn,
                                                input logic [rfa_pkg::INSTR_W-1:0] word,
                                                input logic [rfa_pkg::LOAD_W-1:0] load_val);
        t_idx                         src_a;
        t_idx                         src_b;
        t_idx                         dst;
        logic [rfa_pkg::RESULT_W-1:0] a;
        logic [rfa_pkg::RESULT_W-1:0] b;
        logic [rfa_pkg::RESULT_W-1:0] mag_a;
        logic [rfa_pkg::RESULT_W-1:0] mag_b;
        logic [rfa_pkg::RESULT_W-1:0] value;
        logic                         wr;
        t_alu_result                  res;
        src_a = word[rfa_pkg::SRC_A_POS +: rfa_pkg::IDX_W];
        src_b = word[rfa_pkg::SRC_B_POS +: rfa_pkg::IDX_W];
        dst   = word[rfa_pkg::DEST_POS +: rfa_pkg::IDX_W];
        a     = reg_model[src_a];
        b     = reg_model[src_b];
        value = '0;
        wr    = 1'b1;
        res.divide_by_zero = 1'b0;
        case (fn)
            rfa_pkg::FN_ADD:  value = a + b;
            rfa_pkg::FN_SUB:  value = a - b;
            rfa_pkg::FN_MUL:  value = a * b;
            rfa_pkg::FN_DIV: begin
                if (b == '0) begin
                    wr = 1'b0;
                    res.divide_by_zero = 1'b1;
                end else begin
                    // Divide magnitudes, then negate when the signs differ.
                    mag_a = a[rfa_pkg::RESULT_W-1] ? -a : a;
                    mag_b = b[rfa_pkg::RESULT_W-1] ? -b : b;
                    value = mag_a / mag_b;
                    if (a[rfa_pkg::RESULT_W-1] ^ b[rfa_pkg::RESULT_W-1]) begin
                        value = -value;
                    end
                end
            end
            rfa_pkg::FN_LOAD: value = load_val;
            default: wr = 1'b0;
        endcase
        if (wr) begin
            reg_model[dst] = value;
        end
        res.result     = wr ? value : '0;
        res.dest_index = dst;
        return res;
    endfunction

    // Instruction word with the given register fields and random other bits.
    function automatic logic [rfa_pkg::INSTR_W-1:0] instr_word(input int src_a,
                                                               input int src_b,
                                                               input int dst);
        logic [rfa_pkg::INSTR_W-1:0] word;
        word = $urandom;
        word[rfa_pkg::SRC_A_POS +: rfa_pkg::IDX_W] = t_idx'(src_a);
        word[rfa_pkg::SRC_B_POS +: rfa_pkg::IDX_W] = t_idx'(src_b);
        word[rfa_pkg::DEST_POS +: rfa_pkg::IDX_W]  = t_idx'(dst);
        return word;
    endfunction

    task automatic queue_cmd(input t_func_code fn, input logic [rfa_pkg::INSTR_W-1:0] word,
                             input logic [rfa_pkg::LOAD_W-1:0] load_val);
        t_alu_cmd cmd;
        cmd.func        = fn;
        cmd.instruction = word;
        cmd.load_value  = load_val;
        cmd_q.push_back(cmd);
    endtask

    // Register indices mostly come from a small set so that loaded values get reused.
    function automatic int pick_reg();
        return ($urandom_range(0, 99) < 70) ? $urandom_range(0, 7)
                                            : $urandom_range(0, NUM_REGS - 1);
    endfunction

    function automatic logic [rfa_pkg::LOAD_W-1:0] pick_load_value();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 20) begin
            case ($urandom_range(0, 4))
                0:       return 32'h8000_0000;
                1:       return 32'h7FFF_FFFF;
                2:       return 32'hFFFF_FFFF;
                3:       return 32'h0000_0000;
                default: return 32'h0000_0001;
            endcase
        end else if (sel < 50) begin
            return $urandom_range(0, 40) - 20;
        end
        return $urandom;
    endfunction

    function automatic t_func_code pick_func();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 25) return rfa_pkg::FN_LOAD;
        if (sel < 43) return rfa_pkg::FN_ADD;
        if (sel < 58) return rfa_pkg::FN_SUB;
        if (sel < 74) return rfa_pkg::FN_MUL;
        if (sel < 94) return rfa_pkg::FN_DIV;
        return t_func_code'($urandom_range(FN_UNUSED_FIRST, FN_UNUSED_LAST));
    endfunction

    wire quiet = (accepted_count >= QUIET_FIRST) && (accepted_count < QUIET_LAST);

    // Input side: records accepted items and predicts their results.
    always @(posedge i_clk) begin
        in_fire <= i_rst_n && alu_in.valid && alu_in.ready;
        if (i_rst_n && alu_in.valid && alu_in.ready) begin
            writeback_q.push_back(alu_execute(alu_in.func, alu_in.instruction,
                                              alu_in.load_value));
            op_seen[alu_in.func]++;
            accepted_count++;
        end
    end

    always @(negedge i_clk) begin : drive
        t_alu_cmd cmd;
        if (!i_rst_n) begin
            alu_in.valid <= 1'b0;
        end else if (!alu_in.valid || in_fire) begin
            if (cmd_q.size() == 0 || (!quiet && $urandom_range(0, 99) < IDLE_PERCENT)) begin
                alu_in.valid <= 1'b0;
            end else begin
                cmd = cmd_q.pop_front();
                alu_in.func        <= cmd.func;
                alu_in.instruction <= cmd.instruction;
                alu_in.load_value  <= cmd.load_value;
                alu_in.valid       <= 1'b1;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            alu_out.ready <= 1'b0;
        end else begin
            alu_out.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    always @(posedge i_clk) begin : check
        t_alu_result want;
        if (i_rst_n && alu_out.valid && alu_out.ready) begin
            if (alu_out.divide_by_zero) begin
                zero_div_count++;
            end
            if (writeback_q.size() == 0) begin
                $display("%0t: unexpected item: result %h dest %0d divide_by_zero %b",
                         $time, alu_out.result, alu_out.dest_index, alu_out.divide_by_zero);
                mismatch_count++;
            end else begin
                want = writeback_q.pop_front();
                if (alu_out.result !== want.result) begin
                    $display("%0t: result mismatch: expected %h, actual %h",
                             $time, want.result, alu_out.result);
                    mismatch_count++;
                end
                if (alu_out.dest_index !== want.dest_index) begin
                    $display("%0t: dest_index mismatch: expected %0d, actual %0d",
                             $time, want.dest_index, alu_out.dest_index);
                    mismatch_count++;
                end
                if (alu_out.divide_by_zero !== want.divide_by_zero) begin
                    $display("%0t: divide_by_zero mismatch: expected %b, actual %b",
                             $time, want.divide_by_zero, alu_out.divide_by_zero);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d items pending and %0d results outstanding",
                     $time, cmd_q.size(), writeback_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int unused_ops;
        alu_in.valid       = 1'b0;
        alu_in.func        = '0;
        alu_in.instruction = '0;
        alu_in.load_value  = '0;
        alu_out.ready      = 1'b0;
        i_rst_n            = 1'b0;
        foreach (reg_model[i]) reg_model[i] = '0;
        foreach (op_seen[i]) op_seen[i] = 0;

        // Directed part: extreme operands, every operation and the corner cases.
        queue_cmd(rfa_pkg::FN_LOAD, instr_word(pick_reg(), pick_reg(), 1), 32'h7FFF_FFFF);
        queue_cmd(rfa_pkg::FN_LOAD, instr_word(pick_reg(), pick_reg(), 2), 32'h8000_0000);
        queue_cmd(rfa_pkg::FN_LOAD, instr_word(pick_reg(), pick_reg(), 3), 32'hFFFF_FFFF);
        queue_cmd(rfa_pkg::FN_LOAD, instr_word(pick_reg(), pick_reg(), 4), 32'h0000_0001);
        queue_cmd(rfa_pkg::FN_LOAD, instr_word(pick_reg(), pick_reg(), 13), -7);
        queue_cmd(rfa_pkg::FN_LOAD, instr_word(pick_reg(), pick_reg(), 14), 2);
        queue_cmd(rfa_pkg::FN_ADD, instr_word(1, 4, 6), '0);
        queue_cmd(rfa_pkg::FN_SUB, instr_word(2, 4, 7), '0);
        queue_cmd(rfa_pkg::FN_MUL, instr_word(1, 1, 8), '0);
        queue_cmd(rfa_pkg::FN_MUL, instr_word(2, 3, 9), '0);
        // Most negative value over minus one wraps back to itself.
        queue_cmd(rfa_pkg::FN_DIV, instr_word(2, 3, 10), '0);
        queue_cmd(rfa_pkg::FN_DIV, instr_word(1, 0, 11), '0);
        queue_cmd(rfa_pkg::FN_DIV, instr_word(13, 14, 15), '0);
        queue_cmd(rfa_pkg::FN_DIV, instr_word(3, 1, 12), '0);
        queue_cmd(rfa_pkg::FN_DIV, instr_word(2, 2, 16), '0);
        // Sources are read before the destination is written.
        queue_cmd(rfa_pkg::FN_ADD, instr_word(1, 1, 1), '0);
        queue_cmd(rfa_pkg::FN_SUB, instr_word(0, 3, 63), '0);
        for (int fn = FN_UNUSED_FIRST; fn <= FN_UNUSED_LAST; fn++) begin
            queue_cmd(t_func_code'(fn), instr_word(1, 2, 62), 32'hFFFF_FFFF);
        end
        queue_cmd(rfa_pkg::FN_LOAD, '1, 32'hFFFF_FFFF);
        queue_cmd(rfa_pkg::FN_ADD, '0, '0);
        queue_cmd(rfa_pkg::FN_MUL, instr_word(63, 63, 0), '0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            queue_cmd(pick_func(), instr_word(pick_reg(), pick_reg(), pick_reg()),
                      pick_load_value());
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_q.size() != 0 || alu_in.valid || writeback_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        unused_ops = 0;
        for (int fn = FN_UNUSED_FIRST; fn <= FN_UNUSED_LAST; fn++) begin
            unused_ops += op_seen[fn];
        end
        $display("Checked %0d items: %0d add, %0d sub, %0d multiply, %0d divide, %0d load,",
                 accepted_count, op_seen[rfa_pkg::FN_ADD], op_seen[rfa_pkg::FN_SUB],
                 op_seen[rfa_pkg::FN_MUL], op_seen[rfa_pkg::FN_DIV],
                 op_seen[rfa_pkg::FN_LOAD]);
        $display("%0d with an unused selector and %0d divides by zero; %0d mismatches.",
                 unused_ops, zero_div_count, mismatch_count);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/rfa_pkg.sv
rtl/rfa_in_if.sv
rtl/rfa_out_if.sv
rtl/rfa_ram.sv
rtl/rfa_alu.sv
rtl/register_file_alu_top.sv
tb/tb_register_file_alu_top.sv
